FILE: hw/rtl/tsrr_pkg.sv
// ----------------------------------------------------------------------------
// tsrr_pkg
// shared constants, codes and types for the time-sliced round-robin sharer
// ----------------------------------------------------------------------------
package tsrr_pkg;

  localparam int MAX_MEMBERS = 8;
  localparam int ID_BITS     = 8;
  localparam int IDX_W       = $clog2(MAX_MEMBERS);
  localparam int CNT_W       = $clog2(MAX_MEMBERS + 1);
  localparam int SLICE_W     = 8;
  localparam int DIV_STEPS   = SLICE_W + 1;
  localparam int STEP_W      = $clog2(DIV_STEPS + 1);

  // item modes
  localparam logic [1:0] MODE_TICK   = 2'd0;
  localparam logic [1:0] MODE_ADD    = 2'd1;
  localparam logic [1:0] MODE_REMOVE = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_MISSING = 2'd2;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_SRCH = 7'b0000010,
    S_SHFT = 7'b0000100,
    S_MOD  = 7'b0001000,
    S_RDG  = 7'b0010000,
    S_RDU  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

endpackage

FILE: hw/rtl/time_slice_round_robin_sharer_core.sv
// ----------------------------------------------------------------------------
// time_slice_round_robin_sharer_core
// ordered list of requester ids sharing one resource, granted in time slices
// ----------------------------------------------------------------------------
//
//  channel  ports                                  handshake
//  -------  -------------------------------------  ------------------------
//  input    in_mode, in_id                          start && !busy
//  result   out_granted_valid .. out_status         out_valid, one cycle
//  config   cfg_slot_length                         cfg_valid && cfg_ready
//
// busy is high while an item is being processed
//   add / unused mode / tick with under two : apply, read holder, read next, report
//   tick, two or more : the 9-step serial remainder unit, then read and report
//   remove            : bound by the single-port
//                       member list (one entry compared, then one entry moved per cycle)
// reset is synchronous active low; the member list itself is not cleared
// results cannot be stalled: out_valid pulses for one cycle per item
//
module time_slice_round_robin_sharer_core
  import tsrr_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // input items
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_mode,
  input  logic [ID_BITS-1:0] in_id,
  // results
  output logic               out_valid,
  output logic               out_granted_valid,
  output logic [ID_BITS-1:0] out_granted_id,
  output logic               out_upcoming_valid,
  output logic [ID_BITS-1:0] out_upcoming_id,
  output logic [3:0]         out_member_count,
  output logic [1:0]         out_status,
  // configuration
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [SLICE_W-1:0] cfg_slot_length
);

  // control state
  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [IDX_W-1:0]   holder_r, holder_nxt;
  logic [SLICE_W-1:0] slice_r, slice_nxt;
  logic [SLICE_W-1:0] slot_r;
  logic               chk_v_r, chk_v_nxt;
  logic               wv_r, wv_nxt;
  logic               out_valid_r, out_valid_nxt;

  // working payload
  logic [ID_BITS-1:0] id_r, id_nxt;
  logic [1:0]         status_r, status_nxt;
  logic [CNT_W-1:0]   scan_r, scan_nxt;
  logic [IDX_W-1:0]   chk_idx_r, chk_idx_nxt;
  logic [IDX_W-1:0]   pos_r, pos_nxt;
  logic [CNT_W-1:0]   shf_r, shf_nxt;
  logic [IDX_W-1:0]   wa_r, wa_nxt;
  logic [SLICE_W-1:0] rem_r, rem_nxt;
  logic [SLICE_W:0]   dvd_r, dvd_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic [ID_BITS-1:0] gid_r, gid_nxt;

  // result registers
  logic               out_gv_r, out_gv_nxt;
  logic [ID_BITS-1:0] out_gid_r, out_gid_nxt;
  logic               out_uv_r, out_uv_nxt;
  logic [ID_BITS-1:0] out_uid_r, out_uid_nxt;
  logic [3:0]         out_cnt_r, out_cnt_nxt;
  logic [1:0]         out_st_r, out_st_nxt;

  // member list: single write port, single registered read port
  logic [ID_BITS-1:0] mem [MAX_MEMBERS];
  logic [IDX_W-1:0]   rd_addr;
  logic [ID_BITS-1:0] rd_data_r;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_wa;
  logic [ID_BITS-1:0] mem_wd;

  // shared remainder step and helpers
  logic [SLICE_W-1:0] slot_eff;
  logic [SLICE_W:0]   trial;
  logic [SLICE_W:0]   divisor;
  logic [SLICE_W-1:0] rem_step;
  logic [CNT_W-1:0]   holder_inc;
  logic [IDX_W-1:0]   next_idx;
  logic [CNT_W-1:0]   new_cnt;
  logic [CNT_W-1:0]   pos_inc;

  logic accept;

  assign accept    = start && (state_r == S_IDLE);
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  // a slot length of zero behaves as one
  assign slot_eff = (slot_r == '0) ? SLICE_W'(1) : slot_r;

  // one restoring remainder step: bring in the next dividend bit, subtract if it fits
  assign divisor  = {1'b0, slot_eff};
  assign trial    = {rem_r, dvd_r[SLICE_W]};
  assign rem_step = (trial >= divisor) ? SLICE_W'(trial - divisor) : trial[SLICE_W-1:0];

  // circular successor of the holder
  assign holder_inc = CNT_W'(holder_r) + CNT_W'(1);
  assign next_idx   = (holder_inc >= count_r) ? '0 : holder_inc[IDX_W-1:0];

  // repointing after a remove
  assign new_cnt = count_r - CNT_W'(1);
  assign pos_inc = CNT_W'(pos_r) + CNT_W'(1);

  always_comb begin
    case (state_r)
      S_SRCH:  rd_addr = scan_r[IDX_W-1:0];
      S_SHFT:  rd_addr = shf_r[IDX_W-1:0];
      S_RDG:   rd_addr = holder_r;
      S_RDU:   rd_addr = next_idx;
      default: rd_addr = holder_r;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    holder_nxt    = holder_r;
    slice_nxt     = slice_r;
    chk_v_nxt     = chk_v_r;
    wv_nxt        = wv_r;
    out_valid_nxt = 1'b0;
    id_nxt        = id_r;
    status_nxt    = status_r;
    scan_nxt      = scan_r;
    chk_idx_nxt   = chk_idx_r;
    pos_nxt       = pos_r;
    shf_nxt       = shf_r;
    wa_nxt        = wa_r;
    rem_nxt       = rem_r;
    dvd_nxt       = dvd_r;
    step_nxt      = step_r;
    gid_nxt       = gid_r;
    out_gv_nxt    = out_gv_r;
    out_gid_nxt   = out_gid_r;
    out_uv_nxt    = out_uv_r;
    out_uid_nxt   = out_uid_r;
    out_cnt_nxt   = out_cnt_r;
    out_st_nxt    = out_st_r;
    mem_we        = 1'b0;
    mem_wa        = wa_r;
    mem_wd        = rd_data_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          id_nxt     = in_id;
          status_nxt = ST_OK;
          state_nxt  = S_RDG;
          case (in_mode)
            MODE_TICK: begin
              if (count_r >= CNT_W'(2)) begin
                // counter update goes through the serial remainder unit
                rem_nxt  = '0;
                step_nxt = '0;
                if (slice_r == '0) begin
                  holder_nxt = next_idx;
                  dvd_nxt    = (SLICE_W+1)'(1);
                end else begin
                  dvd_nxt = {1'b0, slice_r} + (SLICE_W+1)'(1);
                end
                state_nxt = S_MOD;
              end
            end
            MODE_ADD: begin
              if (count_r == CNT_W'(MAX_MEMBERS)) begin
                status_nxt = ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_wa    = count_r[IDX_W-1:0];
                mem_wd    = in_id;
                count_nxt = count_r + CNT_W'(1);
                if (count_r <= CNT_W'(1)) begin
                  holder_nxt = '0;
                end
                if (count_r == CNT_W'(1)) begin
                  slice_nxt = '0;
                end
              end
            end
            MODE_REMOVE: begin
              scan_nxt  = '0;
              chk_v_nxt = 1'b0;
              state_nxt = S_SRCH;
            end
            default: ;
          endcase
        end
      end

      S_SRCH: begin
        // one read issued and one entry compared per cycle
        if (chk_v_r && (rd_data_r == id_r)) begin
          pos_nxt   = chk_idx_r;
          shf_nxt   = CNT_W'(chk_idx_r) + CNT_W'(1);
          wv_nxt    = 1'b0;
          chk_v_nxt = 1'b0;
          state_nxt = S_SHFT;
        end else if (!chk_v_r && (scan_r >= count_r)) begin
          status_nxt = ST_MISSING;
          state_nxt  = S_RDG;
        end else begin
          chk_v_nxt   = (scan_r < count_r);
          chk_idx_nxt = scan_r[IDX_W-1:0];
          if (scan_r < count_r) begin
            scan_nxt = scan_r + CNT_W'(1);
          end
        end
      end

      S_SHFT: begin
        // close the gap: read entry k+1, write it to k on the next cycle
        if (wv_r) begin
          mem_we = 1'b1;
          mem_wa = wa_r;
          mem_wd = rd_data_r;
        end
        if (shf_r < count_r) begin
          wv_nxt  = 1'b1;
          wa_nxt  = IDX_W'(shf_r - CNT_W'(1));
          shf_nxt = shf_r + CNT_W'(1);
        end else begin
          wv_nxt = 1'b0;
          if (!wv_r) begin
            count_nxt = new_cnt;
            state_nxt = S_RDG;
            if (new_cnt <= CNT_W'(1)) begin
              holder_nxt = '0;
            end else if (pos_inc >= new_cnt) begin
              holder_nxt = IDX_W'(pos_inc - new_cnt);
            end else begin
              holder_nxt = pos_inc[IDX_W-1:0];
            end
            if (new_cnt == CNT_W'(1)) begin
              slice_nxt = '0;
            end
          end
        end
      end

      S_MOD: begin
        rem_nxt  = rem_step;
        dvd_nxt  = {dvd_r[SLICE_W-1:0], 1'b0};
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(DIV_STEPS - 1)) begin
          slice_nxt = rem_step;
          state_nxt = S_RDG;
        end
      end

      S_RDG: begin
        state_nxt = S_RDU;
      end

      S_RDU: begin
        gid_nxt   = rd_data_r;
        state_nxt = S_OUT;
      end

      S_OUT: begin
        out_valid_nxt = 1'b1;
        out_gv_nxt    = (count_r != '0);
        out_gid_nxt   = (count_r != '0) ? gid_r : '0;
        out_uv_nxt    = (count_r > CNT_W'(1));
        out_uid_nxt   = (count_r > CNT_W'(1)) ? rd_data_r : '0;
        out_cnt_nxt   = 4'(count_r);
        out_st_nxt    = status_r;
        state_nxt     = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      holder_r    <= '0;
      slice_r     <= '0;
      slot_r      <= SLICE_W'(1);
      chk_v_r     <= 1'b0;
      wv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      holder_r    <= holder_nxt;
      slice_r     <= slice_nxt;
      chk_v_r     <= chk_v_nxt;
      wv_r        <= wv_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        slot_r <= cfg_slot_length;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    id_r      <= id_nxt;
    status_r  <= status_nxt;
    scan_r    <= scan_nxt;
    chk_idx_r <= chk_idx_nxt;
    pos_r     <= pos_nxt;
    shf_r     <= shf_nxt;
    wa_r      <= wa_nxt;
    rem_r     <= rem_nxt;
    dvd_r     <= dvd_nxt;
    step_r    <= step_nxt;
    gid_r     <= gid_nxt;
    out_gv_r  <= out_gv_nxt;
    out_gid_r <= out_gid_nxt;
    out_uv_r  <= out_uv_nxt;
    out_uid_r <= out_uid_nxt;
    out_cnt_r <= out_cnt_nxt;
    out_st_r  <= out_st_nxt;
  end

  // member list storage
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign out_valid          = out_valid_r;
  assign out_granted_valid  = out_gv_r;
  assign out_granted_id     = out_gid_r;
  assign out_upcoming_valid = out_uv_r;
  assign out_upcoming_id    = out_uid_r;
  assign out_member_count   = out_cnt_r;
  assign out_status         = out_st_r;

endmodule

FILE: hw/rtl/tsrr_checker.sv
// ----------------------------------------------------------------------------
// tsrr_checker
// port-level checks for the time-sliced round-robin sharer
// ----------------------------------------------------------------------------
module tsrr_checker
  import tsrr_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input logic               out_granted_valid,
  input logic [ID_BITS-1:0] out_granted_id,
  input logic               out_upcoming_valid,
  input logic [ID_BITS-1:0] out_upcoming_id,
  input logic [3:0]         out_member_count
);

  // an accepted item keeps the block busy on the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  // result strobe is a single-cycle pulse
  a_strobe_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held longer than one cycle");

  // grant present exactly when the list is not empty, id zero otherwise
  a_grant_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_granted_valid == (out_member_count != 4'd0)) &&
                  (out_granted_valid || out_granted_id == '0))
    else $error("grant does not agree with member count");

  // a next holder exists exactly when two or more share
  a_upcoming_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_upcoming_valid == (out_member_count > 4'd1)) &&
                  (out_upcoming_valid || out_upcoming_id == '0))
    else $error("next holder does not agree with member count");

  // count never exceeds the list depth
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_member_count <= 4'(MAX_MEMBERS))
    else $error("member count beyond list depth");

endmodule

bind time_slice_round_robin_sharer_core tsrr_checker u_tsrr_checker (.*);
